/* hdl/tle_pkg.sv */
`timescale 1ns / 1ps

package tle_pkg;

    localparam int LINE_CAP = 32;
    localparam int ADDR_W   = $clog2(LINE_CAP);
    localparam int MAX_W    = 5;
    localparam int LIM_W    = (ADDR_W > MAX_W) ? ADDR_W : MAX_W;
    localparam int CFG_W    = 5;
    localparam int CMDQ_DEPTH = 2;

    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_DEL   = 8'h7f;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic CFG_ECHO_ENABLE = 1'b0;
    localparam logic CFG_MAX_CHARS   = 1'b1;

    localparam logic CHAN_ECHO = 1'b0;
    localparam logic CHAN_LINE = 1'b1;

    typedef enum logic [1:0] {
        CMD_CHAR,
        CMD_ERASE,
        CMD_LINE
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] data;
    } t_cmd;

endpackage

/* hdl/tle_ram.sv */
`timescale 1ns / 1ps

module tle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/tle_cmdq.sv */
`timescale 1ns / 1ps

module tle_cmdq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tle_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    output tle_pkg::t_cmd o_cmd,
    input  logic          i_pop
);
    import tle_pkg::*;

    localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

    t_cmd             r_slot [CMDQ_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(CMDQ_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

/* hdl/tle_front.sv */
`timescale 1ns / 1ps

module tle_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_rx_byte,
    output logic          o_push,
    output tle_pkg::t_cmd o_cmd
);
    import tle_pkg::*;

    logic r_skip_lf;
    logic cmd_valid;

    // classify the byte; swallowed lf and plain control bytes give no command
    always_comb begin
        cmd_valid   = 1'b0;
        o_cmd.kind  = CMD_CHAR;
        o_cmd.data  = i_rx_byte;
        unique case (i_rx_byte) inside
            CH_CR: begin
                cmd_valid  = 1'b1;
                o_cmd.kind = CMD_LINE;
            end
            CH_LF: begin
                cmd_valid  = !r_skip_lf;
                o_cmd.kind = CMD_LINE;
            end
            CH_BS, CH_DEL: begin
                cmd_valid  = 1'b1;
                o_cmd.kind = CMD_ERASE;
            end
            default: begin
                cmd_valid  = (i_rx_byte >= CH_SPACE);
                o_cmd.kind = CMD_CHAR;
            end
        endcase
    end

    assign o_push = i_accept && cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_lf <= 1'b0;
        end else if (i_accept) begin
            r_skip_lf <= (i_rx_byte == CH_CR);
        end
    end

endmodule

/* hdl/tle_back.sv */
`timescale 1ns / 1ps

module tle_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_index,
    input  logic [tle_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                      i_cmd_valid,
    input  tle_pkg::t_cmd             i_cmd,
    output logic                      o_cmd_pop,
    output logic                      o_out_valid,
    output logic                      o_channel,
    output logic [7:0]                o_data,
    output logic                      o_last,
    input  logic                      i_pop
);
    import tle_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LF,
        S_ERASE_SP,
        S_ERASE_BS,
        S_RD,
        S_EMIT
    } t_state;

    t_state            r_state,     n_state;
    logic [ADDR_W-1:0] r_fill,      n_fill;
    logic [ADDR_W-1:0] r_idx,       n_idx;
    logic              r_out_valid, n_out_valid;
    logic              r_out_ch,    n_out_ch;
    logic [7:0]        r_out_data,  n_out_data;
    logic              r_out_last,  n_out_last;
    logic              r_echo;
    logic [MAX_W-1:0]  r_max_chars;

    logic              out_free;
    logic              ram_we;
    logic [7:0]        ram_rdata;
    logic [LIM_W-1:0]  limit;

    tle_ram #(
        .WIDTH (8),
        .DEPTH (LINE_CAP)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_fill),
        .i_wdata (i_cmd.data),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        if (LIM_W'(r_max_chars) > LIM_W'(LINE_CAP - 1)) begin
            limit = LIM_W'(LINE_CAP - 1);
        end else begin
            limit = LIM_W'(r_max_chars);
        end
    end

    assign out_free = !r_out_valid || i_pop;

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !i_pop;
        n_out_ch    = r_out_ch;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        o_cmd_pop   = 1'b0;
        ram_we      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.kind)
                        CMD_CHAR: begin
                            if (LIM_W'(r_fill) < limit) begin
                                ram_we = 1'b1;
                                n_fill = r_fill + 1'b1;
                                if (r_echo) begin
                                    n_out_valid = 1'b1;
                                    n_out_ch    = CHAN_ECHO;
                                    n_out_data  = i_cmd.data;
                                    n_out_last  = 1'b1;
                                end
                            end
                        end
                        CMD_ERASE: begin
                            if (r_fill != '0) begin
                                n_fill = r_fill - 1'b1;
                                if (r_echo) begin
                                    n_out_valid = 1'b1;
                                    n_out_ch    = CHAN_ECHO;
                                    n_out_data  = CH_BS;
                                    n_out_last  = 1'b0;
                                    n_state     = S_ERASE_SP;
                                end
                            end
                        end
                        CMD_LINE: begin
                            n_idx = '0;
                            if (r_echo) begin
                                n_out_valid = 1'b1;
                                n_out_ch    = CHAN_ECHO;
                                n_out_data  = CH_CR;
                                n_out_last  = 1'b0;
                                n_state     = S_LF;
                            end else begin
                                n_state = S_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LF: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_ch    = CHAN_ECHO;
                    n_out_data  = CH_LF;
                    n_out_last  = 1'b0;
                    n_state     = S_RD;
                end
            end
            S_ERASE_SP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_ch    = CHAN_ECHO;
                    n_out_data  = CH_SPACE;
                    n_out_last  = 1'b0;
                    n_state     = S_ERASE_BS;
                end
            end
            S_ERASE_BS: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_ch    = CHAN_ECHO;
                    n_out_data  = CH_BS;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_RD: begin
                // ram address settles here, data shows up next cycle
                if (r_idx == r_fill) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out_ch    = CHAN_LINE;
                        n_out_data  = CH_NUL;
                        n_out_last  = 1'b1;
                        n_fill      = '0;
                        n_state     = S_IDLE;
                    end
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_ch    = CHAN_LINE;
                    n_out_data  = ram_rdata;
                    n_out_last  = 1'b0;
                    n_idx       = r_idx + 1'b1;
                    n_state     = S_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            r_echo      <= 1'b1;
            r_max_chars <= MAX_W'(31);
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ECHO_ENABLE: r_echo      <= i_cfg_wdata[0];
                    CFG_MAX_CHARS:   r_max_chars <= i_cfg_wdata[MAX_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
        r_out_ch   <= n_out_ch;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_channel   = r_out_ch;
    assign o_data      = r_out_data;
    assign o_last      = r_out_last;

endmodule

/* hdl/terminal_line_editor.sv */
`timescale 1ns / 1ps

// channel   direction  handshake          payload
// input     in         push / full        i_rx_byte
// result    out        empty / pop        o_channel, o_data, o_last
// config    in         i_cfg_we           i_cfg_index, i_cfg_wdata
//
// printable byte or unechoed erase: idle only; echoed erase: three results (bs, sp, bs)
// a line end echoes cr and then lf when echo is on, then reads each stored byte
// from the line ram and emits it, and ends with the terminator
// synchronous reset empties the command queue and the result register
// a waiting result stalls the back end; full rises once the command queue fills

module terminal_line_editor (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [7:0]                i_rx_byte,
    output logic                      empty,
    input  logic                      pop,
    output logic                      o_channel,
    output logic [7:0]                o_data,
    output logic                      o_last,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_index,
    input  logic [tle_pkg::CFG_W-1:0] i_cfg_wdata
);
    import tle_pkg::*;

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic front_push;
    logic queue_full;
    logic queue_valid;
    logic queue_pop;
    logic out_valid;
    logic in_accept;

    assign in_accept = push && !queue_full;
    assign full      = queue_full;

    tle_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (in_accept),
        .i_rx_byte (i_rx_byte),
        .o_push    (front_push),
        .o_cmd     (front_cmd)
    );

    tle_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .o_cmd   (queue_cmd),
        .i_pop   (queue_pop)
    );

    tle_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd_valid (queue_valid),
        .i_cmd       (queue_cmd),
        .o_cmd_pop   (queue_pop),
        .o_out_valid (out_valid),
        .o_channel   (o_channel),
        .o_data      (o_data),
        .o_last      (o_last),
        .i_pop       (pop)
    );

    assign empty = !out_valid;

endmodule
